// File: src/transactional_key_value_store_core_macros.svh
// Assertion macros for the key-value store checker.
// Used by the checker module only; needs a clock named i_clk and reset i_rst_n in scope.
`ifndef TRANSACTIONAL_KEY_VALUE_STORE_CORE_MACROS_SVH
`define TRANSACTIONAL_KEY_VALUE_STORE_CORE_MACROS_SVH

// same-cycle implication
`define KVS_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define KVS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: src/kvs_pkg.sv
// Shared types and codes for the transactional key-value store.
// No dependencies.
package kvs_pkg;

    localparam logic [2:0] FN_SET      = 3'd0;
    localparam logic [2:0] FN_DELETE   = 3'd1;
    localparam logic [2:0] FN_GET      = 3'd2;
    localparam logic [2:0] FN_BEGIN    = 3'd3;
    localparam logic [2:0] FN_COMMIT   = 3'd4;
    localparam logic [2:0] FN_ROLLBACK = 3'd5;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_MISS = 2'd1;
    localparam logic [1:0] ST_FULL = 2'd2;

    localparam logic signed [31:0] MISSING = -32'sd1;

    typedef struct packed {
        logic [2:0]         func;
        logic signed [31:0] key;
        logic signed [31:0] value;
    } t_req;

    typedef struct packed {
        logic signed [31:0] read_value;
        logic [1:0]         status;
    } t_rsp;

    // controller -> datapath
    typedef struct packed {
        logic load;       // capture request, clear result
        logic scan_clr;   // restart scan counters and hit/free flags
        logic t_step;     // compare table entry, advance
        logic p_step;     // compare pending entry, advance
        logic t_write;    // write key/value at hit or first free slot
        logic t_erase;    // drop hit table entry
        logic p_write;    // write pending entry at hit or first free slot
        logic c_clr;      // commit slot counter to zero
        logic c_inc;      // next commit slot
        logic c_sel;      // pending read address from commit counter
        logic c_load;     // take operation from pending entry
        logic txn_open;
        logic txn_close;
        logic res_val;    // result = recorded hit value
        logic res_miss;   // result = -1, miss
        logic res_nohit;  // status miss only
        logic res_full;
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic t_hit;
        logic t_last;
        logic p_hit;
        logic p_last;
        logic found;
        logic free;
        logic hdel;
        logic in_txn;
        logic cused;
        logic clast;
        logic op_del;
    } t_sts;

endpackage

// File: src/transactional_key_value_store_core.sv
// Top level of the transactional key-value store: controller plus datapath.
// Depends on kvs_pkg, kvs_ctrl, kvs_dp (and kvs_ram below it).
//
// One request at a time: a request is taken when start is high and busy low, and
// its single result appears on o_rsp for one cycle with o_done; the receiver must
// take it then. Timing is set by the linear key search, each entry read through the
// registered RAM, then compared. Begin, rollback and undefined codes need no search.
// Get/set/delete outside a transaction search the table until a hit or its last entry;
// inside a transaction the pending search comes first, and a get that misses there
// adds the table search. A commit inside a transaction walks every pending slot (an
// empty one is skipped) and runs a table search plus write or erase for each used
// slot. No clearing pass after reset.
module transactional_key_value_store_core #(
    parameter int TABLE_ENTRIES   = 64,
    parameter int PENDING_ENTRIES = 16
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          start,
    input  kvs_pkg::t_req i_req,
    output logic          busy,
    output logic          o_done,
    output kvs_pkg::t_rsp o_rsp
);

    kvs_pkg::t_cmd cmd;
    kvs_pkg::t_sts sts;

    kvs_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_func  (i_req.func),
        .i_sts   (sts),
        .o_cmd   (cmd),
        .o_busy  (busy),
        .o_done  (o_done)
    );

    kvs_dp #(
        .TABLE_ENTRIES   (TABLE_ENTRIES),
        .PENDING_ENTRIES (PENDING_ENTRIES)
    ) u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (i_req),
        .i_cmd   (cmd),
        .o_sts   (sts),
        .o_rsp   (o_rsp)
    );

endmodule

// File: src/kvs_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module kvs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                       i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                       o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: src/kvs_dp.sv
// Datapath: table and pending RAMs, used bits, scan counters, result register.
// Depends on kvs_pkg and kvs_ram.
module kvs_dp #(
    parameter int TABLE_ENTRIES   = 64,
    parameter int PENDING_ENTRIES = 16
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  kvs_pkg::t_req i_req,
    input  kvs_pkg::t_cmd i_cmd,
    output kvs_pkg::t_sts o_sts,
    output kvs_pkg::t_rsp o_rsp
);

    localparam int TW = $clog2(TABLE_ENTRIES);
    localparam int PW = (PENDING_ENTRIES > 1) ? $clog2(PENDING_ENTRIES) : 1;

    logic [TABLE_ENTRIES-1:0]   r_tused;
    logic [PENDING_ENTRIES-1:0] r_pused;
    logic                       r_txn;

    logic [TW-1:0] r_tidx, r_tfnd, r_tfree;
    logic [PW-1:0] r_pidx, r_pfnd, r_pfree, r_cidx;
    logic          r_found, r_free, r_hdel;
    logic [31:0]   r_hval;
    logic [31:0]   r_key, r_val;
    logic          r_del;
    logic [31:0]   r_rd;
    logic [1:0]    r_st;

    logic [63:0]   t_rdata;
    logic [64:0]   p_rdata;
    logic [PW-1:0] p_raddr;
    logic          t_hit, p_hit, t_we, p_we;

    assign p_raddr = i_cmd.c_sel ? r_cidx : r_pidx;
    assign t_we    = i_cmd.t_write && (r_found || r_free);
    assign p_we    = i_cmd.p_write && (r_found || r_free);

    kvs_ram #(.WIDTH(64), .DEPTH(TABLE_ENTRIES)) u_tbl (
        .i_clk   (i_clk),
        .i_we    (t_we),
        .i_waddr (r_found ? r_tfnd : r_tfree),
        .i_wdata ({r_key, r_val}),
        .i_raddr (r_tidx),
        .o_rdata (t_rdata)
    );

    kvs_ram #(.WIDTH(65), .DEPTH(PENDING_ENTRIES)) u_pnd (
        .i_clk   (i_clk),
        .i_we    (p_we),
        .i_waddr (r_found ? r_pfnd : r_pfree),
        .i_wdata ({r_del, r_key, r_val}),
        .i_raddr (p_raddr),
        .o_rdata (p_rdata)
    );

    assign t_hit = r_tused[r_tidx] && (t_rdata[63:32] == r_key);
    assign p_hit = r_pused[r_pidx] && (p_rdata[63:32] == r_key);

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tused <= '0;
            r_pused <= '0;
            r_txn   <= 1'b0;
            r_found <= 1'b0;
            r_free  <= 1'b0;
        end else begin
            if (t_we && !r_found) begin
                r_tused[r_tfree] <= 1'b1;
            end
            if (i_cmd.t_erase) begin
                r_tused[r_tfnd] <= 1'b0;
            end
            if (p_we && !r_found) begin
                r_pused[r_pfree] <= 1'b1;
            end
            if (i_cmd.txn_open) begin
                r_txn   <= 1'b1;
                r_pused <= '0;
            end
            if (i_cmd.txn_close) begin
                r_txn   <= 1'b0;
                r_pused <= '0;
            end
            if (i_cmd.scan_clr) begin
                r_found <= 1'b0;
                r_free  <= 1'b0;
            end else if (i_cmd.t_step) begin
                if (t_hit) begin
                    r_found <= 1'b1;
                end else if (!r_tused[r_tidx]) begin
                    r_free <= 1'b1;
                end
            end else if (i_cmd.p_step) begin
                if (p_hit) begin
                    r_found <= 1'b1;
                end else if (!r_pused[r_pidx]) begin
                    r_free <= 1'b1;
                end
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_key <= i_req.key;
            r_val <= i_req.value;
            r_del <= (i_req.func == kvs_pkg::FN_DELETE);
            r_rd  <= '0;
            r_st  <= kvs_pkg::ST_OK;
        end
        if (i_cmd.c_load) begin
            r_key <= p_rdata[63:32];
            r_val <= p_rdata[31:0];
            r_del <= p_rdata[64];
        end
        if (i_cmd.scan_clr) begin
            r_tidx <= '0;
            r_pidx <= '0;
        end
        if (i_cmd.t_step) begin
            r_tidx <= r_tidx + 1'b1;
            if (t_hit) begin
                r_tfnd <= r_tidx;
                r_hval <= t_rdata[31:0];
                r_hdel <= 1'b0;
            end else if (!r_tused[r_tidx] && !r_free) begin
                r_tfree <= r_tidx;
            end
        end
        if (i_cmd.p_step) begin
            r_pidx <= r_pidx + 1'b1;
            if (p_hit) begin
                r_pfnd <= r_pidx;
                r_hval <= p_rdata[31:0];
                r_hdel <= p_rdata[64];
            end else if (!r_pused[r_pidx] && !r_free) begin
                r_pfree <= r_pidx;
            end
        end
        if (i_cmd.c_clr) begin
            r_cidx <= '0;
        end else if (i_cmd.c_inc) begin
            r_cidx <= r_cidx + 1'b1;
        end
        if (i_cmd.res_val) begin
            r_rd <= r_hval;
            r_st <= kvs_pkg::ST_OK;
        end
        if (i_cmd.res_miss) begin
            r_rd <= kvs_pkg::MISSING;
            r_st <= kvs_pkg::ST_MISS;
        end
        if (i_cmd.res_nohit) begin
            r_st <= kvs_pkg::ST_MISS;
        end
        if (i_cmd.res_full) begin
            r_st <= kvs_pkg::ST_FULL;
        end
    end

    assign o_sts.t_hit  = t_hit;
    assign o_sts.t_last = (r_tidx == TW'(TABLE_ENTRIES - 1));
    assign o_sts.p_hit  = p_hit;
    assign o_sts.p_last = (r_pidx == PW'(PENDING_ENTRIES - 1));
    assign o_sts.found  = r_found;
    assign o_sts.free   = r_free;
    assign o_sts.hdel   = r_hdel;
    assign o_sts.in_txn = r_txn;
    assign o_sts.cused  = r_pused[r_cidx];
    assign o_sts.clast  = (r_cidx == PW'(PENDING_ENTRIES - 1));
    assign o_sts.op_del = r_del;

    assign o_rsp.read_value = r_rd;
    assign o_rsp.status     = r_st;

endmodule

// File: src/kvs_ctrl.sv
// Controller state machine: sequences scans, writes and the commit walk.
// Depends on kvs_pkg.
module kvs_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [2:0]    i_func,
    input  kvs_pkg::t_sts i_sts,
    output kvs_pkg::t_cmd o_cmd,
    output logic          o_busy,
    output logic          o_done
);

    typedef enum logic [10:0] {
        S_IDLE  = 11'b000_0000_0001,
        S_T_RD  = 11'b000_0000_0010,
        S_T_CMP = 11'b000_0000_0100,
        S_T_ACT = 11'b000_0000_1000,
        S_P_RD  = 11'b000_0001_0000,
        S_P_CMP = 11'b000_0010_0000,
        S_P_ACT = 11'b000_0100_0000,
        S_C_RD  = 11'b000_1000_0000,
        S_C_LD  = 11'b001_0000_0000,
        S_C_END = 11'b010_0000_0000,
        S_DONE  = 11'b100_0000_0000
    } t_state;

    t_state     r_state, n_state;
    logic [2:0] r_func, n_func;
    logic       r_commit, n_commit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_func   <= kvs_pkg::FN_SET;
            r_commit <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_func   <= n_func;
            r_commit <= n_commit;
        end
    end

    always_comb begin
        n_state  = r_state;
        n_func   = r_func;
        n_commit = r_commit;
        o_cmd    = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.load = 1'b1;
                    n_func     = i_func;
                    n_commit   = 1'b0;
                    n_state    = S_DONE;
                    unique case (i_func) inside
                        kvs_pkg::FN_SET, kvs_pkg::FN_DELETE, kvs_pkg::FN_GET: begin
                            o_cmd.scan_clr = 1'b1;
                            n_state = i_sts.in_txn ? S_P_RD : S_T_RD;
                        end
                        kvs_pkg::FN_BEGIN: begin
                            o_cmd.txn_open = 1'b1;
                        end
                        kvs_pkg::FN_COMMIT: begin
                            if (i_sts.in_txn) begin
                                o_cmd.c_clr = 1'b1;
                                n_commit    = 1'b1;
                                n_state     = S_C_RD;
                            end
                        end
                        kvs_pkg::FN_ROLLBACK: begin
                            o_cmd.txn_close = i_sts.in_txn;
                        end
                        default: ;
                    endcase
                end
            end
            S_T_RD: n_state = S_T_CMP;
            S_T_CMP: begin
                o_cmd.t_step = 1'b1;
                n_state = (i_sts.t_hit || i_sts.t_last) ? S_T_ACT : S_T_RD;
            end
            S_T_ACT: begin
                if (r_func == kvs_pkg::FN_GET) begin
                    o_cmd.res_val  = i_sts.found;
                    o_cmd.res_miss = !i_sts.found;
                end else if (i_sts.op_del) begin
                    o_cmd.t_erase   = i_sts.found;
                    o_cmd.res_nohit = !i_sts.found && !r_commit;
                end else begin
                    o_cmd.t_write  = 1'b1;
                    o_cmd.res_full = !i_sts.found && !i_sts.free;
                end
                if (!r_commit) begin
                    n_state = S_DONE;
                end else if (i_sts.clast) begin
                    n_state = S_C_END;
                end else begin
                    o_cmd.c_inc = 1'b1;
                    n_state = S_C_RD;
                end
            end
            S_P_RD: n_state = S_P_CMP;
            S_P_CMP: begin
                o_cmd.p_step = 1'b1;
                n_state = (i_sts.p_hit || i_sts.p_last) ? S_P_ACT : S_P_RD;
            end
            S_P_ACT: begin
                n_state = S_DONE;
                if (r_func == kvs_pkg::FN_GET) begin
                    if (i_sts.found) begin
                        o_cmd.res_miss = i_sts.hdel;
                        o_cmd.res_val  = !i_sts.hdel;
                    end else begin
                        // not pending: fall through to the table
                        o_cmd.scan_clr = 1'b1;
                        n_state = S_T_RD;
                    end
                end else begin
                    o_cmd.p_write  = 1'b1;
                    o_cmd.res_full = !i_sts.found && !i_sts.free;
                end
            end
            S_C_RD: begin
                o_cmd.c_sel = 1'b1;
                if (i_sts.cused) begin
                    n_state = S_C_LD;
                end else if (i_sts.clast) begin
                    n_state = S_C_END;
                end else begin
                    o_cmd.c_inc = 1'b1;
                end
            end
            S_C_LD: begin
                o_cmd.c_load   = 1'b1;
                o_cmd.scan_clr = 1'b1;
                n_state = S_T_RD;
            end
            S_C_END: begin
                o_cmd.txn_close = 1'b1;
                n_state = S_DONE;
            end
            S_DONE: n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    assign o_busy = (r_state != S_IDLE);
    assign o_done = (r_state == S_DONE);

endmodule

// File: src/kvs_chk.sv
// Port-level checker for the key-value store, bound to the top level.
// Depends on kvs_pkg and the macros header.
`include "transactional_key_value_store_core_macros.svh"

module kvs_chk (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          start,
    input logic          busy,
    input logic          o_done,
    input kvs_pkg::t_rsp o_rsp
);

    `KVS_ASSERT_NEXT(a_take_busy, start && !busy, busy, "request taken but block not busy")
    `KVS_ASSERT_NEXT(a_done_free, o_done, !busy && !o_done, "block not free after result")
    `KVS_ASSERT_NOW(a_done_busy, o_done, busy, "result strobe outside a request")
    `KVS_ASSERT_NOW(a_status, o_done, o_rsp.status == kvs_pkg::ST_OK || o_rsp.status == kvs_pkg::ST_MISS || o_rsp.status == kvs_pkg::ST_FULL, "illegal status code")
    `KVS_ASSERT_NOW(a_full_zero, o_done && o_rsp.status == kvs_pkg::ST_FULL, o_rsp.read_value == 32'sd0, "full status with nonzero read value")

endmodule

bind transactional_key_value_store_core kvs_chk u_kvs_chk (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .start   (start),
    .busy    (busy),
    .o_done  (o_done),
    .o_rsp   (o_rsp)
);

// File: tb/sv/tb_transactional_key_value_store_core.sv
// Testbench for transactional_key_value_store_core: random and directed requests,
// with a built-in predictor of the table and the pending buffer checked against o_rsp.
// Depends on kvs_pkg and the store RTL.
`timescale 1ns / 100ps

module tb_transactional_key_value_store_core;

    localparam int TBL_N  = 64;
    localparam int PEND_N = 16;
    localparam logic [2:0] FN_BAD6 = 3'd6;
    localparam logic [2:0] FN_BAD7 = 3'd7;

    typedef struct {
        kvs_pkg::t_req req;
        bit            drain;   // hold until every result is back
    } t_item;

    logic          i_clk   = 1'b0;
    logic          i_rst_n = 1'b0;
    logic          start   = 1'b0;
    kvs_pkg::t_req req_d   = '0;
    logic          busy;
    logic          o_done;
    kvs_pkg::t_rsp o_rsp;

    transactional_key_value_store_core DUT (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .start  (start),
        .i_req  (req_d),
        .busy   (busy),
        .o_done (o_done),
        .o_rsp  (o_rsp)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // model state
    logic [31:0] tbl_key [TBL_N];
    logic [31:0] tbl_val [TBL_N];
    bit          tbl_used[TBL_N];
    logic [31:0] pnd_key [PEND_N];
    logic [31:0] pnd_val [PEND_N];
    bit          pnd_del [PEND_N];
    bit          pnd_used[PEND_N];
    bit          txn_open = 1'b0;

    t_item         pending_reqs[$];
    kvs_pkg::t_rsp expected_rsp[$];
    int            n_queued = 0;
    int            n_taken  = 0;
    int            n_errors = 0;

    initial begin
        foreach (tbl_used[i]) tbl_used[i] = 1'b0;
        foreach (pnd_used[i]) pnd_used[i] = 1'b0;
    end

    function automatic int tbl_lookup(logic [31:0] k);
        for (int i = 0; i < TBL_N; i++)
            if (tbl_used[i] && tbl_key[i] == k) return i;
        return -1;
    endfunction

    function automatic int pnd_lookup(logic [31:0] k);
        for (int i = 0; i < PEND_N; i++)
            if (pnd_used[i] && pnd_key[i] == k) return i;
        return -1;
    endfunction

    function automatic logic [1:0] tbl_store(logic [31:0] k, logic [31:0] v);
        int i;
        i = tbl_lookup(k);
        if (i < 0) begin
            for (i = 0; i < TBL_N; i++)
                if (!tbl_used[i]) break;
            if (i >= TBL_N) return kvs_pkg::ST_FULL;
            tbl_used[i] = 1'b1;
            tbl_key[i]  = k;
        end
        tbl_val[i] = v;
        return kvs_pkg::ST_OK;
    endfunction

    function automatic logic [1:0] tbl_erase(logic [31:0] k);
        int i;
        i = tbl_lookup(k);
        if (i < 0) return kvs_pkg::ST_MISS;
        tbl_used[i] = 1'b0;
        return kvs_pkg::ST_OK;
    endfunction

    function automatic logic [1:0] pnd_store(logic [31:0] k, logic [31:0] v, bit del);
        int i;
        i = pnd_lookup(k);
        if (i < 0) begin
            for (i = 0; i < PEND_N; i++)
                if (!pnd_used[i]) break;
            if (i >= PEND_N) return kvs_pkg::ST_FULL;
            pnd_used[i] = 1'b1;
            pnd_key[i]  = k;
        end
        pnd_val[i] = v;
        pnd_del[i] = del;
        return kvs_pkg::ST_OK;
    endfunction

    // applies one request to the model store, returns the response it yields
    function automatic kvs_pkg::t_rsp kv_apply(kvs_pkg::t_req r);
        kvs_pkg::t_rsp rsp;
        int            i;
        rsp.read_value = '0;
        rsp.status     = kvs_pkg::ST_OK;
        case (r.func)
            kvs_pkg::FN_SET:
                rsp.status = txn_open ? pnd_store(r.key, r.value, 1'b0)
                                      : tbl_store(r.key, r.value);
            kvs_pkg::FN_DELETE:
                rsp.status = txn_open ? pnd_store(r.key, '0, 1'b1) : tbl_erase(r.key);
            kvs_pkg::FN_GET: begin
                i = txn_open ? pnd_lookup(r.key) : -1;
                if (i >= 0) begin
                    if (pnd_del[i]) begin
                        rsp.read_value = kvs_pkg::MISSING;
                        rsp.status     = kvs_pkg::ST_MISS;
                    end else begin
                        rsp.read_value = pnd_val[i];
                    end
                end else begin
                    i = tbl_lookup(r.key);
                    if (i >= 0) begin
                        rsp.read_value = tbl_val[i];
                    end else begin
                        rsp.read_value = kvs_pkg::MISSING;
                        rsp.status     = kvs_pkg::ST_MISS;
                    end
                end
            end
            kvs_pkg::FN_BEGIN: begin
                txn_open = 1'b1;
                foreach (pnd_used[j]) pnd_used[j] = 1'b0;
            end
            kvs_pkg::FN_COMMIT: begin
                if (txn_open) begin
                    for (int j = 0; j < PEND_N; j++) begin
                        if (!pnd_used[j]) continue;
                        if (pnd_del[j]) begin
                            void'(tbl_erase(pnd_key[j]));
                        end else if (tbl_store(pnd_key[j], pnd_val[j]) == kvs_pkg::ST_FULL)
                        begin
                            rsp.status = kvs_pkg::ST_FULL;
                        end
                    end
                    foreach (pnd_used[j]) pnd_used[j] = 1'b0;
                    txn_open = 1'b0;
                end
            end
            kvs_pkg::FN_ROLLBACK: begin
                if (txn_open) begin
                    foreach (pnd_used[j]) pnd_used[j] = 1'b0;
                    txn_open = 1'b0;
                end
            end
            default: ;
        endcase
        return rsp;
    endfunction

    task automatic push_req(logic [2:0] f, logic [31:0] k, logic [31:0] v, bit drain = 1'b0);
        t_item it;
        it.req.func  = f;
        it.req.key   = k;
        it.req.value = v;
        it.drain     = drain;
        pending_reqs.push_back(it);
        n_queued++;
    endtask

    // mostly a small pool around zero so keys collide and the table fills
    function automatic logic [31:0] pick_key();
        if ($urandom_range(0, 9) < 8) return $urandom_range(0, 79) - 40;
        return $urandom;
    endfunction

    function automatic logic [2:0] pick_data_op();
        int w;
        w = $urandom_range(0, 99);
        if (w < 50) return kvs_pkg::FN_SET;
        if (w < 70) return kvs_pkg::FN_DELETE;
        return kvs_pkg::FN_GET;
    endfunction

    // driver: bursts of requests with random gaps
    int    burst_left = 0;
    int    gap_left   = 0;
    t_item next_item;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
        end else begin
            if (start && !busy) begin
                expected_rsp.push_back(kv_apply(req_d));
                n_taken++;
            end
            if (!start || !busy) begin
                if (gap_left > 0) begin
                    gap_left--;
                    start <= 1'b0;
                end else if (pending_reqs.size() > 0 &&
                             !(pending_reqs[0].drain &&
                               (expected_rsp.size() > 0 || (start && !busy)))) begin
                    next_item = pending_reqs.pop_front();
                    req_d <= next_item.req;
                    start <= 1'b1;
                    if (burst_left > 0) begin
                        burst_left--;
                    end else begin
                        burst_left = $urandom_range(1, 30);
                        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                    end
                end else begin
                    start <= 1'b0;
                end
            end
        end
    end

    // monitor: every strobed result is checked against the oldest expectation
    always @(posedge i_clk) begin
        if (i_rst_n && o_done) begin
            if (expected_rsp.size() == 0) begin
                $display("%0t: unexpected result read_value=%h status=%0d",
                         $time, o_rsp.read_value, o_rsp.status);
                n_errors++;
            end else begin
                kvs_pkg::t_rsp want;
                want = expected_rsp.pop_front();
                if (o_rsp.read_value !== want.read_value) begin
                    $display("%0t: read_value mismatch expected %h actual %h",
                             $time, want.read_value, o_rsp.read_value);
                    n_errors++;
                end
                if (o_rsp.status !== want.status) begin
                    $display("%0t: status mismatch expected %0d actual %0d",
                             $time, want.status, o_rsp.status);
                    n_errors++;
                end
            end
        end
    end

    initial begin
        int n;
        int n_drain;
        n_drain = 0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: extremes, every function, the corner cases
        push_req(kvs_pkg::FN_GET,      32'h0000_0005, 32'h0);
        push_req(kvs_pkg::FN_DELETE,   32'h0000_0005, 32'h0);
        push_req(kvs_pkg::FN_COMMIT,   32'h0, 32'h0);
        push_req(kvs_pkg::FN_ROLLBACK, 32'h0, 32'h0);
        push_req(kvs_pkg::FN_SET,      32'h8000_0000, 32'h7FFF_FFFF);
        push_req(kvs_pkg::FN_SET,      32'h7FFF_FFFF, 32'hFFFF_FFFF);
        push_req(kvs_pkg::FN_SET,      32'hFFFF_FFFF, 32'h8000_0000);
        push_req(kvs_pkg::FN_GET,      32'h7FFF_FFFF, 32'h0);
        push_req(kvs_pkg::FN_SET,      32'h8000_0000, 32'h0000_0000);
        push_req(kvs_pkg::FN_GET,      32'h8000_0000, 32'h0);
        push_req(FN_BAD6,              32'hFFFF_FFFF, 32'hFFFF_FFFF);
        push_req(FN_BAD7,              32'h0, 32'h0);
        push_req(kvs_pkg::FN_BEGIN,    32'h0, 32'h0);
        push_req(kvs_pkg::FN_SET,      32'h0000_0001, 32'h1234_5678);
        push_req(kvs_pkg::FN_DELETE,   32'h7FFF_FFFF, 32'h0);
        push_req(kvs_pkg::FN_GET,      32'h7FFF_FFFF, 32'h0);
        push_req(kvs_pkg::FN_GET,      32'hFFFF_FFFF, 32'h0);
        push_req(kvs_pkg::FN_BEGIN,    32'h0, 32'h0);
        push_req(kvs_pkg::FN_GET,      32'h0000_0001, 32'h0);
        push_req(kvs_pkg::FN_DELETE,   32'h8000_0000, 32'h0);
        push_req(kvs_pkg::FN_COMMIT,   32'h0, 32'h0);
        push_req(kvs_pkg::FN_GET,      32'h8000_0000, 32'h0);
        push_req(kvs_pkg::FN_BEGIN,    32'h0, 32'h0);
        push_req(kvs_pkg::FN_SET,      32'h0000_0002, 32'hDEAD_BEEF);
        push_req(kvs_pkg::FN_ROLLBACK, 32'h0, 32'h0);

        // random: mostly transactions with random content, plus loose requests
        while (n_queued < 1270) begin
            if (n_queued > 600 && n_drain < 20) begin
                push_req(kvs_pkg::FN_GET, pick_key(), $urandom, 1'b1);
                n_drain++;
            end else if ($urandom_range(0, 9) < 6) begin
                push_req(kvs_pkg::FN_BEGIN, $urandom, $urandom);
                n = ($urandom_range(0, 4) == 0) ? $urandom_range(14, 22)
                                                : $urandom_range(1, 10);
                repeat (n) begin
                    if ($urandom_range(0, 39) == 0)
                        push_req(kvs_pkg::FN_BEGIN, $urandom, $urandom);
                    else
                        push_req(pick_data_op(), pick_key(), $urandom);
                end
                case ($urandom_range(0, 9))
                    0, 1, 2:  push_req(kvs_pkg::FN_ROLLBACK, $urandom, $urandom);
                    3:        ;
                    default:  push_req(kvs_pkg::FN_COMMIT, $urandom, $urandom);
                endcase
            end else begin
                n = $urandom_range(0, 99);
                if (n < 95)
                    push_req(pick_data_op(), pick_key(), $urandom);
                else if (n < 97)
                    push_req(($urandom_range(0, 1) != 0) ? kvs_pkg::FN_COMMIT
                                                         : kvs_pkg::FN_ROLLBACK,
                             $urandom, $urandom);
                else
                    push_req(($urandom_range(0, 1) != 0) ? FN_BAD6 : FN_BAD7,
                             $urandom, $urandom);
            end
        end

        wait (n_taken == n_queued && expected_rsp.size() == 0);
        repeat (50) @(posedge i_clk);
        if (n_errors == 0 && expected_rsp.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

    initial begin
        #200_000_000;
        $display("TEST FAILED");
        $finish;
    end

endmodule
